>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  // default number of cells in the queue
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int PRIO_W = 8;
  localparam int TAG_W  = 16;
  localparam int OCC_W  = 5;

  // operation codes carried on the op field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  logic               left_occ,
  input  logic               left_gt,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_next,
  output logic               gt
);
  import spq_pkg::*;

  // new entry goes in front of this one only on strictly greater priority
  assign gt = occ && (entry.prio > ctrl.new_entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (occ) begin
        if (gt) begin
          entry_next = left_gt ? left_entry : ctrl.new_entry;
        end
      end else if (left_occ) begin
        // first free cell: takes the shifted entry or the new one
        entry_next = left_gt ? left_entry : ctrl.new_entry;
      end
    end else if (ctrl.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> rtl/stable_priority_queue.sv
`timescale 1ns / 1ps

// Bounded priority queue built as a row of QUEUE_DEPTH cells that stays sorted by
// priority, lowest number at cell 0. An insert is broadcast to all cells at once:
// every cell compares its own priority with the new one and either holds, takes
// its left neighbor's entry or takes the new entry, so ties leave in arrival
// order. A remove shifts every cell one place toward the head. Each accepted
// transfer passes through the cell row and gives exactly one result, which
// sits in an output register; a new transfer is taken in the same cycle as the
// previous result leaves, so the queue sustains one item per clock and only a
// stalled output holds it back. Remove on empty reports status 1, insert on full
// is dropped with status 2; neither changes the queue. Reset empties the queue.
module stable_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  new_priority,
  input  logic [15:0] new_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  removed_priority,
  output logic [15:0] removed_tag,
  output logic [7:0]  head_priority,
  output logic [15:0] head_tag,
  output logic        is_empty,
  output logic [4:0]  occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // fill count; with out_valid, the only reset state of the queue
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic in_xfer;
  logic do_insert;
  logic do_remove;
  logic is_full;

  cell_ctrl_t ctrl;

  entry_t entry_q   [QUEUE_DEPTH];
  entry_t entry_nx  [QUEUE_DEPTH];
  logic   cell_gt   [QUEUE_DEPTH];
  logic   cell_occ  [QUEUE_DEPTH];

  // output register
  status_t           result_status;
  entry_t            result_removed;
  entry_t            result_head;
  logic              result_empty;
  logic [OCC_W-1:0]  result_occ;

  status_t step_status;
  entry_t  step_removed;
  entry_t  step_head;

  // a new transfer is taken while the held result leaves
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign is_full   = (count == CW'(QUEUE_DEPTH));
  assign do_insert = in_xfer && (op == OP_INSERT) && !is_full;
  assign do_remove = in_xfer && (op == OP_REMOVE) && (count != '0);

  assign ctrl.insert         = do_insert;
  assign ctrl.remove         = do_remove;
  assign ctrl.new_entry.prio = new_priority;
  assign ctrl.new_entry.tag  = new_tag;

  // cell chain: left neighbor is toward the head, right toward the tail
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_gt;
    logic   left_occ;

    assign cell_occ[i] = (count > CW'(i));

    if (i == 0) begin : g_head
      // head cell: nothing to its left, always eligible for the new entry
      assign left_entry = '0;
      assign left_gt    = 1'b0;
      assign left_occ   = 1'b1;
    end else begin : g_body
      assign left_entry = entry_q[i-1];
      assign left_gt    = cell_gt[i-1];
      assign left_occ   = cell_occ[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      // tail cell is past the count after a remove, contents unused
      assign right_entry = entry_q[i];
    end else begin : g_mid
      assign right_entry = entry_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (cell_occ[i]),
      .left_occ    (left_occ),
      .left_gt     (left_gt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_q[i]),
      .entry_next  (entry_nx[i]),
      .gt          (cell_gt[i])
    );
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CW'(1);
    end else if (do_remove) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    step_status = ST_OK;
    if (op == OP_REMOVE && count == '0) begin
      step_status = ST_EMPTY;
    end else if (op == OP_INSERT && is_full) begin
      step_status = ST_FULL;
    end
  end

  // removed entry is the old head; head after the step is the head cell's next value
  assign step_removed = do_remove ? entry_q[0] : '0;
  assign step_head    = (count_next != '0) ? entry_nx[0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_status  <= step_status;
      result_removed <= step_removed;
      result_head    <= step_head;
      result_empty   <= (count_next == '0);
      result_occ     <= OCC_W'(count_next);
    end
  end

  assign status           = result_status;
  assign removed_priority = result_removed.prio;
  assign removed_tag      = result_removed.tag;
  assign head_priority    = result_head.prio;
  assign head_tag         = result_head.tag;
  assign is_empty         = result_empty;
  assign occupancy        = result_occ;

  // fill count never runs past the cell row
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  // the two front cells stay in priority order
  a_sorted_front : assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (entry_q[0].prio <= entry_q[1].prio))
    else $error("head cells out of order");

  // a remove on an empty queue leaves it empty
  a_empty_remove : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op == OP_REMOVE && count == '0) |=> (count == '0))
    else $error("remove on empty changed the queue");

  // an accepted insert with room grows the queue by one
  a_insert_grow : assert property (@(posedge clk) disable iff (rst)
    (in_xfer && op == OP_INSERT && !is_full) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the queue");

endmodule
